/* hdl/mclp_pkg.sv */
package mclp_pkg;

    localparam int MAX_ITEMS   = 1024;
    localparam int WEIGHT_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int GRP_W       = CNT_W + 1;
    localparam int TOTAL_W     = 26;
    localparam int TRIPS_W     = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [CNT_W-1:0]   ITEMS_FULL = CNT_W'(MAX_ITEMS);

    // Register indexes of the configuration port.
    localparam logic REG_MAX_TRIPS = 1'b0;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic                   last_weight;
    } t_in;

    typedef struct packed {
        logic [TOTAL_W-1:0] min_capacity;
        logic               overflowed;
    } t_out;

    // One classified beat passed from the front to the back.
    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic                   last;
        logic                   keep;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PROBE,
        ST_SCAN,
        ST_JUDGE
    } t_state;

endpackage

/* hdl/mclp_front.sv */
module mclp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  mclp_pkg::t_in    i_item,
    output mclp_pkg::t_cmd   o_cmd
);
    import mclp_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             keep;

    // A weight is kept only while the store still has room for it.
    assign keep = (r_count < ITEMS_FULL);

    always_comb begin
        n_count = r_count;
        if (i_accept) begin
            if (i_item.last_weight) begin
                n_count = '0;
            end else if (keep) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_cmd.weight = i_item.weight;
    assign o_cmd.last   = i_item.last_weight;
    assign o_cmd.keep   = keep;

endmodule

/* hdl/mclp_queue.sv */
module mclp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mclp_pkg::t_cmd   i_data,
    input  logic             i_pop,
    output mclp_pkg::t_cmd   o_data,
    output logic             o_empty,
    output logic             o_full
);
    import mclp_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_level;
    logic              do_push;
    logic              do_pop;

    assign o_empty = (r_level == '0);
    assign o_full  = (r_level == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + (QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_level <= r_level - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

/* hdl/mclp_back.sv */
module mclp_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mclp_pkg::t_cmd                 i_cmd,
    input  logic                           i_empty,
    output logic                           o_pop,
    input  logic [mclp_pkg::TRIPS_W-1:0]   i_max_trips,
    output logic                           o_strobe,
    output mclp_pkg::t_out                 o_result
);
    import mclp_pkg::*;

    logic [WEIGHT_BITS-1:0] mem [MAX_ITEMS];
    logic [WEIGHT_BITS-1:0] r_rdata;

    t_state             r_state,  n_state;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [TOTAL_W-1:0] r_total,  n_total;
    logic               r_ovf,    n_ovf;
    logic [TOTAL_W-1:0] r_lo,     n_lo;
    logic [TOTAL_W-1:0] r_hi,     n_hi;
    logic [TOTAL_W-1:0] r_mid,    n_mid;
    logic [TOTAL_W-1:0] r_load,   n_load;
    logic [GRP_W-1:0]   r_groups, n_groups;
    logic               r_fail,   n_fail;
    logic [CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic               r_dv,     n_dv;

    logic               mem_we;
    logic [TOTAL_W:0]   total_sum;
    logic [TOTAL_W:0]   span_sum;
    logic [TOTAL_W:0]   load_sum;
    logic [TOTAL_W-1:0] rd_weight;

    assign total_sum = {1'b0, r_total} + (TOTAL_W + 1)'(i_cmd.weight);
    assign span_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign rd_weight = TOTAL_W'(r_rdata);
    assign load_sum  = {1'b0, r_load} + {1'b0, rd_weight};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[ADDR_W-1:0]] <= i_cmd.weight;
        end
        r_rdata <= mem[r_rd_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_ovf   <= n_ovf;
            r_dv    <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_load   <= n_load;
        r_groups <= n_groups;
        r_fail   <= n_fail;
        r_rd_idx <= n_rd_idx;
    end

    assign o_result.min_capacity = r_hi;
    assign o_result.overflowed   = r_ovf;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_total  = r_total;
        n_ovf    = r_ovf;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_load   = r_load;
        n_groups = r_groups;
        n_fail   = r_fail;
        n_rd_idx = r_rd_idx;
        n_dv     = 1'b0;
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        o_strobe = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.keep) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                        n_total = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_cmd.last) begin
                        n_lo    = '0;
                        n_hi    = n_total;
                        n_state = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (({1'b0, r_lo} + (TOTAL_W + 1)'(1)) < {1'b0, r_hi}) begin
                    n_mid    = span_sum[TOTAL_W:1];
                    n_load   = '0;
                    n_groups = GRP_W'(1);
                    n_fail   = 1'b0;
                    n_rd_idx = '0;
                    n_state  = ST_SCAN;
                end else begin
                    o_strobe = 1'b1;
                    n_count  = '0;
                    n_total  = '0;
                    n_ovf    = 1'b0;
                    n_state  = ST_LOAD;
                end
            end
            ST_SCAN: begin
                if (r_rd_idx != r_count) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                    n_dv     = 1'b1;
                end
                if (r_dv) begin
                    if (load_sum <= {1'b0, r_mid}) begin
                        n_load = load_sum[TOTAL_W-1:0];
                    end else begin
                        n_groups = r_groups + GRP_W'(1);
                        n_load   = rd_weight;
                        if (rd_weight > r_mid) begin
                            n_fail = 1'b1;
                        end
                    end
                end
                if ((r_rd_idx == r_count) && !r_dv) begin
                    n_state = ST_JUDGE;
                end
            end
            ST_JUDGE: begin
                if (!r_fail && (r_groups <= GRP_W'(i_max_trips))) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid;
                end
                n_state = ST_PROBE;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

/* hdl/min_capacity_linear_partition_top.sv */
// Loading: one weight beat per cycle; busy rises only once the four-beat queue has filled.
// After the last beat, each search step walks every stored weight once and about
// log2(total) steps are made; the result strobe follows the final step in the next cycle.
// Throughput is set by the single read port of the weight store, walked once per step.
// Reset is synchronous and active low; it empties the queue, clears the set and sets
// max_trips to 1. The receiver cannot stall: o_strobe is high for exactly one cycle.
module min_capacity_linear_partition_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Command channel
    input  logic                start,
    output logic                busy,
    input  mclp_pkg::t_in       i_item,
    // Result channel
    output logic                o_strobe,
    output mclp_pkg::t_out      o_result,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import mclp_pkg::*;

    logic               accept;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    t_cmd               front_cmd;
    t_cmd               back_cmd;
    logic [TRIPS_W-1:0] r_max_trips;
    logic               reg_sel;

    // The front takes a beat whenever the queue has room. The back may be deep in a
    // search at that time; the queue lets both halves stall independently.
    assign busy   = q_full;
    assign accept = start && !busy;

    // Register decode uses the word address only; the single register sits at 0.
    assign reg_sel = (paddr[2] == REG_MAX_TRIPS);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? 32'(r_max_trips) : '0;

    // The user must write configuration only while the block is idle (the block does
    // not enforce this), so the back may use the register directly throughout a search.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_trips <= TRIPS_W'(1);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_max_trips <= pwdata[TRIPS_W-1:0];
        end
    end

    // The front classifies each beat: a weight arriving once the store is full is
    // marked to be dropped, and the back records the overflow instead of storing it.
    mclp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_cmd    (front_cmd)
    );

    mclp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_data   (front_cmd),
        .i_pop    (q_pop),
        .o_data   (back_cmd),
        .o_empty  (q_empty),
        .o_full   (q_full)
    );

    // The back stores and totals the weights, then binary-searches the capacity with
    // one greedy packing pass over the store per probe.
    mclp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (back_cmd),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .i_max_trips (r_max_trips),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule
